// ===== sv/sdus_pkg.sv =====
package sdus_pkg;

  localparam int unsigned MaxNeighbours = 16;
  localparam int unsigned CoordW = 24;
  localparam logic [15:0] StepReset = 16'd4096;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    KIND_CENTRE = 1'b0,
    KIND_NEIGH  = 1'b1
  } kind_e;

  // one classified input word
  typedef struct packed {
    kind_e             kind;
    logic              border;
    logic              last;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
  } cmd_t;

  // result flags, highest bit first; kept is bit 0 on the port
  typedef struct packed {
    logic overflow;
    logic kept;
  } res_flags_t;

endpackage

// ===== sv/sdus_front.sv =====
module sdus_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [71:0]         in_data_i,
  input  logic [1:0]          in_user_i,
  input  logic                in_last_i,
  output logic                cmd_valid_o,
  output sdus_pkg::cmd_t      cmd_o,
  input  logic                cmd_pop_i
);

  sdus_pkg::cmd_t q_mem [sdus_pkg::QueueDepth];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  sdus_pkg::cmd_t cmd_in;
  logic           push, pop;

  // decode the incoming word into a command
  always_comb begin
    cmd_in.kind   = in_user_i[0] ? sdus_pkg::KIND_NEIGH : sdus_pkg::KIND_CENTRE;
    cmd_in.border = in_user_i[1];
    cmd_in.last   = in_last_i;
    cmd_in.pos_x  = in_data_i[23:0];
    cmd_in.pos_y  = in_data_i[47:24];
    cmd_in.pos_z  = in_data_i[71:48];
  end

  assign in_ready_o  = (cnt_q != 2'(sdus_pkg::QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/sdus_back.sv =====
module sdus_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  cmd_valid_i,
  input  sdus_pkg::cmd_t        cmd_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [71:0]           out_data_o,
  output sdus_pkg::res_flags_t  out_flags_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_ROOT, ST_WMUL, ST_FIN, ST_DIV1,
    ST_MULQ, ST_MULR, ST_DIV2, ST_ADD, ST_OUT
  } state_e;

  state_e      state_q;
  logic [15:0] step_q;
  logic [23:0] cen_q [3];
  logic        border_q, degen_q, excess_q, last_q;
  logic [4:0]  cnt_q;
  logic [28:0] lsum_q;
  logic [53:0] ws_q [3];
  logic [24:0] d_q [3];
  logic [1:0]  idx_q, axis_q;
  logic [51:0] prod_q;
  logic [49:0] sq_q;
  logic [26:0] rem_q;
  logic [24:0] root_q;
  logic [5:0]  it_q;
  logic [53:0] div_d_q;
  logic [28:0] div_r_q;
  logic [40:0] acc_q;
  logic        neg_q;
  logic [23:0] res_q [3];
  logic        kept_q;
  logic        out_valid_q;
  logic [71:0] out_data_q;
  sdus_pkg::res_flags_t out_flags_q;

  // shared signed multiplier
  logic [1:0]         sel;
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] prod;
  // small unsigned multiplier for the step scaling
  logic [28:0]        mul2_b;
  logic [44:0]        mul2;
  // root, divider and final add
  logic [28:0]        rt_t, rt_trial;
  logic               rt_ge;
  logic [29:0]        dv_t;
  logic               dv_ge;
  logic [28:0]        dv_r;
  logic [45:0]        tot;
  logic signed [35:0] moved;
  logic [23:0]        sat;
  logic [1:0]         nxt_axis;
  logic [53:0]        nxt_w;
  logic               kept_cond;

  always_comb begin
    sel   = (idx_q == 2'd3) ? 2'd0 : idx_q;
    mul_b = $signed({d_q[sel][24], d_q[sel]});
    mul_a = (state_q == ST_SQ) ? mul_b : $signed({1'b0, root_q});
    prod  = mul_a * mul_b;

    mul2_b = (state_q == ST_MULQ) ? div_d_q[28:0] : div_r_q;
    mul2   = step_q * mul2_b;

    rt_t     = {rem_q, sq_q[49:48]};
    rt_trial = {2'b00, root_q, 2'b01};
    rt_ge    = (rt_t >= rt_trial);

    dv_t  = {div_r_q, div_d_q[53]};
    dv_ge = (dv_t >= {1'b0, lsum_q});
    dv_r  = dv_ge ? 29'(dv_t - {1'b0, lsum_q}) : dv_t[28:0];

    tot   = {5'd0, acc_q} + {1'b0, div_d_q[44:0]};
    moved = neg_q ? ($signed({{12{cen_q[axis_q][23]}}, cen_q[axis_q]})
                     - $signed({2'b00, tot[45:12]}))
                  : ($signed({{12{cen_q[axis_q][23]}}, cen_q[axis_q]})
                     + $signed({2'b00, tot[45:12]}));
    if (moved > 36'sd8388607)        sat = 24'h7FFFFF;
    else if (moved < -36'sd8388608)  sat = 24'h800000;
    else                             sat = moved[23:0];

    nxt_axis  = (state_q == ST_ADD) ? axis_q + 2'd1 : 2'd0;
    nxt_w     = ws_q[nxt_axis];
    kept_cond = border_q || degen_q || (cnt_q == 5'd0) || (lsum_q == 29'd0);
  end

  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_flags_o = out_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= sdus_pkg::StepReset;
      for (int i = 0; i < 3; i++) begin
        cen_q[i] <= '0;
        ws_q[i]  <= '0;
        d_q[i]   <= '0;
        res_q[i] <= '0;
      end
      border_q    <= 1'b0;
      degen_q     <= 1'b0;
      excess_q    <= 1'b0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      lsum_q      <= '0;
      idx_q       <= '0;
      axis_q      <= '0;
      prod_q      <= '0;
      sq_q        <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      it_q        <= '0;
      div_d_q     <= '0;
      div_r_q     <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      kept_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_flags_q <= '0;
    end else begin
      if (cfg_valid_i) step_q <= cfg_data_i;
      // in ST_OUT the result register is reloaded below instead
      if (out_valid_q && out_ready_i && state_q != ST_OUT) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            last_q <= cmd_i.last;
            state_q <= cmd_i.last ? ST_FIN : ST_IDLE;
            if (cmd_i.kind == sdus_pkg::KIND_CENTRE) begin
              cen_q[0] <= cmd_i.pos_x;
              cen_q[1] <= cmd_i.pos_y;
              cen_q[2] <= cmd_i.pos_z;
              border_q <= cmd_i.border;
              degen_q  <= 1'b0;
              excess_q <= 1'b0;
              cnt_q    <= '0;
              lsum_q   <= '0;
              for (int i = 0; i < 3; i++) ws_q[i] <= '0;
            end else if (!degen_q) begin
              if (cnt_q >= 5'(sdus_pkg::MaxNeighbours)) begin
                excess_q <= 1'b1;
              end else begin
                d_q[0]  <= {cmd_i.pos_x[23], cmd_i.pos_x} - {cen_q[0][23], cen_q[0]};
                d_q[1]  <= {cmd_i.pos_y[23], cmd_i.pos_y} - {cen_q[1][23], cen_q[1]};
                d_q[2]  <= {cmd_i.pos_z[23], cmd_i.pos_z} - {cen_q[2][23], cen_q[2]};
                idx_q   <= '0;
                sq_q    <= '0;
                state_q <= ST_SQ;
              end
            end
          end
        end
        ST_SQ: begin
          prod_q <= prod;
          if (idx_q != 2'd0) sq_q <= sq_q + prod_q[49:0];
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            state_q <= ST_ROOT;
            it_q    <= '0;
            rem_q   <= '0;
            root_q  <= '0;
          end
        end
        ST_ROOT: begin
          sq_q   <= {sq_q[47:0], 2'b00};
          rem_q  <= rt_ge ? 27'(rt_t - rt_trial) : rt_t[26:0];
          root_q <= {root_q[23:0], rt_ge};
          it_q   <= it_q + 6'd1;
          if (it_q == 6'd24) begin
            state_q <= ST_WMUL;
            idx_q   <= '0;
          end
        end
        ST_WMUL: begin
          prod_q <= prod;
          if (idx_q != 2'd0) begin
            ws_q[idx_q - 2'd1] <= ws_q[idx_q - 2'd1] + {{2{prod_q[51]}}, prod_q};
          end
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            cnt_q   <= cnt_q + 5'd1;
            lsum_q  <= lsum_q + {4'd0, root_q};
            degen_q <= (root_q == 25'd0);
            state_q <= last_q ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (kept_cond) begin
            kept_q  <= 1'b1;
            res_q   <= cen_q;
            state_q <= ST_OUT;
          end else begin
            kept_q  <= 1'b0;
            axis_q  <= nxt_axis;
            neg_q   <= nxt_w[53];
            div_d_q <= nxt_w[53] ? 54'(-nxt_w) : nxt_w;
            div_r_q <= '0;
            it_q    <= '0;
            state_q <= ST_DIV1;
          end
        end
        ST_DIV1, ST_DIV2: begin
          div_d_q <= {div_d_q[52:0], dv_ge};
          div_r_q <= dv_r;
          it_q    <= it_q + 6'd1;
          if (it_q == 6'd53) state_q <= (state_q == ST_DIV1) ? ST_MULQ : ST_ADD;
        end
        ST_MULQ: begin
          acc_q   <= mul2[40:0];
          state_q <= ST_MULR;
        end
        ST_MULR: begin
          div_d_q <= {9'd0, mul2};
          div_r_q <= '0;
          it_q    <= '0;
          state_q <= ST_DIV2;
        end
        ST_ADD: begin
          res_q[axis_q] <= sat;
          if (axis_q == 2'd2) begin
            state_q <= ST_OUT;
          end else begin
            axis_q  <= nxt_axis;
            neg_q   <= nxt_w[53];
            div_d_q <= nxt_w[53] ? 54'(-nxt_w) : nxt_w;
            div_r_q <= '0;
            it_q    <= '0;
            state_q <= ST_DIV1;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            out_data_q           <= {res_q[2], res_q[1], res_q[0]};
            out_flags_q.kept     <= kept_q;
            out_flags_q.overflow <= excess_q;
            border_q <= 1'b0;
            degen_q  <= 1'b0;
            excess_q <= 1'b0;
            cnt_q    <= '0;
            lsum_q   <= '0;
            for (int i = 0; i < 3; i++) ws_q[i] <= '0;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV1 || state_q == ST_DIV2) |-> (lsum_q != 29'd0))
    else $error("divide by zero edge length sum");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == ST_IDLE))
    else $error("command taken while busy");

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(sdus_pkg::MaxNeighbours))
    else $error("neighbour count beyond limit");

  a_out_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("result not presented");

endmodule

// ===== sv/scale_dependent_umbrella_smooth_core.sv =====
// Centre word: latched by the back end in its idle state, after the queue. Neighbour
// word: 3 squares on the shared multiplier, a 25-step integer root, 3 weighted products.
// Closing a non-kept vertex runs, per axis, two 54-step restoring divisions by the
// edge-length sum plus scaling and add; a kept vertex goes straight to the output.
// Input queue holds 2 words; result sits in an output register until taken.
// Reset (rst_ni, async, low): step 1.0, centre and accumulators cleared, queue and result register empty.
module scale_dependent_umbrella_smooth_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: smoothing step
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // pos_x[23:0], pos_y[47:24], pos_z[71:48]
  input  logic [1:0]  s_axis_tuser,  // op[0], is_border[1]
  input  logic        s_axis_tlast,  // last
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // new_x[23:0], new_y[47:24], new_z[71:48]
  output logic [1:0]  m_axis_tuser   // kept[0], overflow[1]
);

  sdus_pkg::cmd_t       cmd;
  logic                 cmd_valid, cmd_pop;
  sdus_pkg::res_flags_t flags;

  // the user must write the register only while idle; the block does not enforce it, so always ready
  assign cfg_ready_o = 1'b1;

  // front: takes words and classifies centre / neighbour into a short queue
  sdus_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: accumulation, root, division and the result register
  sdus_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_flags_o (flags)
  );

  assign m_axis_tuser = {flags.overflow, flags.kept};

endmodule
